// ===== sv/ir_beam_scan_sequencer_unit_assert.svh =====
// Assertion macros shared by the scan sequencer checkers.
// No dependencies; each macro expects clk_i and rst_ni in scope.
`ifndef IR_BEAM_SCAN_SEQUENCER_UNIT_ASSERT_SVH
`define IR_BEAM_SCAN_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define IBSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ir_beam_scan_sequencer_unit: check failed");

// Next-cycle implication, disabled while reset is asserted
`define IBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ir_beam_scan_sequencer_unit: check failed");

`endif

// ===== sv/ibss_pkg.sv =====
// Shared types and constants for the IR beam scan sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package ibss_pkg;

  // Number of scanned channels (2 to 8)
  localparam int CHANNELS  = 8;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MUX_W     = 3;
  localparam int MASK_W    = 8;
  localparam int STATUS_W  = 8;
  localparam int REG_W     = 8;
  localparam int CNT_W     = 9;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;

  localparam logic [STATUS_W-1:0] CHAN_MASK = STATUS_W'((1 << CHANNELS) - 1);
  localparam logic [CNT_W-1:0]    CNT_MAX   = '1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ON_WINDOW      = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF_WINDOW     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAP_TICKS      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_ON_HITS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_OFF_MISSES = 3'd4;

  // Register reset values
  localparam logic [REG_W-1:0] RST_ON_WINDOW      = 8'd10;
  localparam logic [REG_W-1:0] RST_OFF_WINDOW     = 8'd5;
  localparam logic [REG_W-1:0] RST_GAP_TICKS      = 8'd10;
  localparam logic [REG_W-1:0] RST_MIN_ON_HITS    = 8'd1;
  localparam logic [REG_W-1:0] RST_MIN_OFF_MISSES = 8'd2;

  // Scan phases
  typedef enum logic [2:0] {
    PH_SELECT  = 3'd0,
    PH_ON_SMP  = 3'd1,
    PH_OFF     = 3'd2,
    PH_OFF_SMP = 3'd3,
    PH_GAP     = 3'd4
  } phase_e;

  typedef struct packed {
    logic [REG_W-1:0] on_window;
    logic [REG_W-1:0] off_window;
    logic [REG_W-1:0] gap_ticks;
    logic [REG_W-1:0] min_on_hits;
    logic [REG_W-1:0] min_off_misses;
  } cfg_t;

  typedef struct packed {
    logic [MUX_W-1:0]    mux_select;
    logic [MASK_W-1:0]   emitter_mask;
    logic [STATUS_W-1:0] status_bits;
    logic                all_detected;
    logic                channel_done;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/ibss_cfg_regs.sv =====
// APB-style configuration register file for the scan sequencer.
// Depends on ibss_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module ibss_cfg_regs
  import ibss_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t             cfg_q, cfg_d;
  logic [IDX_W-1:0] idx;
  logic             wr_en;
  logic [REG_W-1:0] wr_val;
  logic [REG_W-1:0] rd_val;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[REG_W-1:0];

  // Write decode; out-of-range indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ON_WINDOW:      cfg_d.on_window      = wr_val;
        REG_OFF_WINDOW:     cfg_d.off_window     = wr_val;
        REG_GAP_TICKS:      cfg_d.gap_ticks      = wr_val;
        REG_MIN_ON_HITS:    cfg_d.min_on_hits    = wr_val;
        REG_MIN_OFF_MISSES: cfg_d.min_off_misses = wr_val;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_window      <= RST_ON_WINDOW;
      cfg_q.off_window     <= RST_OFF_WINDOW;
      cfg_q.gap_ticks      <= RST_GAP_TICKS;
      cfg_q.min_on_hits    <= RST_MIN_ON_HITS;
      cfg_q.min_off_misses <= RST_MIN_OFF_MISSES;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ON_WINDOW:      rd_val = cfg_q.on_window;
      REG_OFF_WINDOW:     rd_val = cfg_q.off_window;
      REG_GAP_TICKS:      rd_val = cfg_q.gap_ticks;
      REG_MIN_ON_HITS:    rd_val = cfg_q.min_on_hits;
      REG_MIN_OFF_MISSES: rd_val = cfg_q.min_off_misses;
      default:            rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);
  assign cfg_o  = cfg_q;

endmodule

`default_nettype wire

// ===== sv/ibss_scan_core.sv =====
// Scan state and per-tick next-state logic of the IR beam sequencer.
// Depends on ibss_pkg for phase_e, cfg_t and result_t.
`default_nettype none

module ibss_scan_core
  import ibss_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic rx_a_i,
  input  wire logic rx_b_i,
  input  wire cfg_t cfg_i,
  output result_t   res_o
);

  phase_e              phase_q, phase_d;
  logic [CH_W-1:0]     channel_q, channel_d;
  logic [REG_W-1:0]    tick_q, tick_d;
  logic [CNT_W-1:0]    on_hits_q, on_hits_d;
  logic [CNT_W-1:0]    off_miss_q, off_miss_d;
  logic [STATUS_W-1:0] detected_q, detected_d;
  logic                emit_q, emit_d;
  logic                done;
  logic                hit;
  logic                pass;
  logic [STATUS_W-1:0] ch_bit;
  logic [CH_W-1:0]     channel_nxt;

  assign hit    = rx_a_i && rx_b_i;
  assign ch_bit = STATUS_W'(1) << channel_q;
  assign pass   = (off_miss_d > CNT_W'(cfg_i.min_off_misses)) &&
                  (on_hits_q  > CNT_W'(cfg_i.min_on_hits));
  assign channel_nxt = (channel_q == CH_W'(CHANNELS - 1)) ? '0 : channel_q + 1'b1;

  // Next state for one tick
  always_comb begin
    phase_d    = phase_q;
    channel_d  = channel_q;
    tick_d     = tick_q;
    on_hits_d  = on_hits_q;
    off_miss_d = off_miss_q;
    detected_d = detected_q;
    emit_d     = emit_q;
    done       = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_SELECT: begin
          emit_d    = 1'b1;
          tick_d    = cfg_i.on_window;
          on_hits_d = '0;
          phase_d   = PH_ON_SMP;
        end
        PH_ON_SMP: begin
          if (hit && on_hits_q != CNT_MAX) on_hits_d = on_hits_q + 1'b1;
          if (tick_q != '0) tick_d = tick_q - 1'b1;
          else              phase_d = PH_OFF;
        end
        PH_OFF: begin
          emit_d     = 1'b0;
          tick_d     = cfg_i.off_window;
          off_miss_d = '0;
          phase_d    = PH_OFF_SMP;
        end
        PH_OFF_SMP: begin
          if (!hit && off_miss_q != CNT_MAX) off_miss_d = off_miss_q + 1'b1;
          if (tick_q != '0) begin
            tick_d = tick_q - 1'b1;
          end else begin
            // decision tick: update this channel's flag and move on
            detected_d = (pass ? (detected_q | ch_bit) : (detected_q & ~ch_bit))
                         & CHAN_MASK;
            done       = 1'b1;
            channel_d  = channel_nxt;
            tick_d     = cfg_i.gap_ticks;
            phase_d    = PH_GAP;
          end
        end
        PH_GAP: begin
          if (tick_q != '0) tick_d = tick_q - 1'b1;
          else              phase_d = PH_SELECT;
        end
        default: phase_d = PH_SELECT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SELECT;
      channel_q  <= '0;
      tick_q     <= '0;
      on_hits_q  <= '0;
      off_miss_q <= '0;
      detected_q <= '0;
      emit_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      channel_q  <= channel_d;
      tick_q     <= tick_d;
      on_hits_q  <= on_hits_d;
      off_miss_q <= off_miss_d;
      detected_q <= detected_d;
      emit_q     <= emit_d;
    end
  end

  // Result fields reflect the state after this tick, except all_detected
  always_comb begin
    res_o.mux_select   = MUX_W'(channel_d);
    res_o.emitter_mask = emit_d ? (MASK_W'(1) << channel_d) : '0;
    res_o.status_bits  = detected_d;
    res_o.all_detected = ((detected_q & CHAN_MASK) == CHAN_MASK);
    res_o.channel_done = done;
  end

endmodule

`default_nettype wire

// ===== sv/ir_beam_scan_sequencer_unit.sv =====
// IR beam scan sequencer: takes one receiver sample request per clock and returns
// one result request per tick. A request passes an input register, then the scan
// core's next-state logic loads the output register, where its result appears. One
// request is accepted every cycle in steady state when the output is not stalled. The
// input register stalls only while it holds a request that the output register,
// still stalled, cannot yet take. Configuration is an APB-style port (registers at
// 4*index, 8 bits each) and must be written only while no request is in flight.
// Depends on ibss_pkg, ibss_cfg_regs and ibss_scan_core.
`default_nettype none

module ir_beam_scan_sequencer_unit
  import ibss_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                rx_a_i,
  input  wire logic                rx_b_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [MUX_W-1:0]    mux_select_o,
  output logic      [MASK_W-1:0]   emitter_mask_o,
  output logic      [STATUS_W-1:0] status_bits_o,
  output logic                     all_detected_o,
  output logic                     channel_done_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    in_valid_q, in_valid_d;
  logic    rx_a_q, rx_b_q;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    step;
  logic    in_take;

  ibss_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Handshake between input register and output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step)          out_valid_d = 1'b1;
    else if (out_free) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input sample register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rx_a_q <= rx_a_i;
      rx_b_q <= rx_b_i;
    end
  end

  ibss_scan_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .rx_a_i(rx_a_q),
    .rx_b_i(rx_b_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign mux_select_o   = res_q.mux_select;
  assign emitter_mask_o = res_q.emitter_mask;
  assign status_bits_o  = res_q.status_bits;
  assign all_detected_o = res_q.all_detected;
  assign channel_done_o = res_q.channel_done;

endmodule

`default_nettype wire

// ===== sv/ibss_checker.sv =====
// Port-level checks for the IR beam scan sequencer, bound to the top level.
// Depends on ibss_pkg and ir_beam_scan_sequencer_unit_assert.svh.
`default_nettype none

`include "ir_beam_scan_sequencer_unit_assert.svh"

module ibss_checker
  import ibss_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [MUX_W-1:0]    mux_select_o,
  input wire logic [MASK_W-1:0]   emitter_mask_o,
  input wire logic [STATUS_W-1:0] status_bits_o,
  input wire logic                channel_done_o
);

  // lit emitter always matches the selected channel
  `IBSS_ASSERT_NOW(a_emit_sel, out_valid_o && emitter_mask_o != '0, emitter_mask_o == (MASK_W'(1) << mux_select_o))

  // at most one emitter lit
  `IBSS_ASSERT_NOW(a_emit_onehot, out_valid_o, $onehot0(emitter_mask_o))

  // decision happens with the emitter off
  `IBSS_ASSERT_NOW(a_done_dark, out_valid_o && channel_done_o, emitter_mask_o == '0)

  // no status bit beyond the channel count
  `IBSS_ASSERT_NOW(a_status_range, out_valid_o, (status_bits_o & ~CHAN_MASK) == '0)

  // stalled result holds
  `IBSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_bits_o) && $stable(mux_select_o))

endmodule

bind ir_beam_scan_sequencer_unit ibss_checker u_ibss_checker (.*);

`default_nettype wire

// ===== tb/ir_beam_scan_sequencer_unit_tb.sv =====
// Self-checking testbench for the IR beam scan sequencer unit.
// Depends on ibss_pkg and ir_beam_scan_sequencer_unit; drives ticks, APB writes
// and random stalls, and checks every tick result against its own scan predictor.
module ir_beam_scan_sequencer_unit_tb;
  import ibss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_REGS    = 5;
  localparam int MAX_IDLE    = 5;
  localparam int DRAIN_WAIT  = 8;

  // Indexes past the register file, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // What the beam of one channel looks like to its receivers
  typedef enum int {
    SC_CLEAR,
    SC_BLOCKED,
    SC_AMBIENT,
    SC_HALF_A,
    SC_HALF_B,
    SC_NOISE
  } scene_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                rx_a_i         = 1'b0;
  logic                rx_b_i         = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [MUX_W-1:0]    mux_select_o;
  logic [MASK_W-1:0]   emitter_mask_o;
  logic [STATUS_W-1:0] status_bits_o;
  logic                all_detected_o;
  logic                channel_done_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ir_beam_scan_sequencer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_a_i         (rx_a_i),
    .rx_b_i         (rx_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mux_select_o   (mux_select_o),
    .emitter_mask_o (emitter_mask_o),
    .status_bits_o  (status_bits_o),
    .all_detected_o (all_detected_o),
    .channel_done_o (channel_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow registers and predicted scan state
  cfg_t                scan_cfg   = '{RST_ON_WINDOW, RST_OFF_WINDOW, RST_GAP_TICKS,
                                      RST_MIN_ON_HITS, RST_MIN_OFF_MISSES};
  phase_e              p_phase    = PH_SELECT;
  logic [CH_W-1:0]     p_chan     = '0;
  logic [REG_W-1:0]    p_cnt      = '0;
  logic [CNT_W-1:0]    p_hits     = '0;
  logic [CNT_W-1:0]    p_misses   = '0;
  logic [STATUS_W-1:0] p_detected = '0;
  logic                p_emit     = 1'b0;

  result_t             tick_result_q[$];
  scene_e              chan_scene[CHANNELS];
  bit                  idle_en    = 1'b1;
  int                  err_cnt    = 0;
  int                  n_sent     = 0;
  int                  n_checked  = 0;
  int                  n_decided  = 0;
  int                  n_all_set  = 0;
  int                  stall_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run watchdog
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Predict one tick: advance the scan state and return the outputs it shows
  function automatic result_t scan_tick(input logic line_a, input logic line_b);
    result_t             res;
    logic                hit;
    logic                all_set;
    logic                decided;
    logic [STATUS_W-1:0] chan_bit;
    hit     = line_a & line_b;
    all_set = ((p_detected & CHAN_MASK) == CHAN_MASK);
    decided = 1'b0;
    case (p_phase)
      PH_SELECT: begin
        p_emit  = 1'b1;
        p_cnt   = scan_cfg.on_window;
        p_hits  = '0;
        p_phase = PH_ON_SMP;
      end
      PH_ON_SMP: begin
        if (hit && p_hits != CNT_MAX) p_hits = p_hits + 1'b1;
        if (p_cnt != '0) p_cnt = p_cnt - 1'b1;
        else p_phase = PH_OFF;
      end
      PH_OFF: begin
        p_emit   = 1'b0;
        p_cnt    = scan_cfg.off_window;
        p_misses = '0;
        p_phase  = PH_OFF_SMP;
      end
      PH_OFF_SMP: begin
        if (!hit && p_misses != CNT_MAX) p_misses = p_misses + 1'b1;
        if (p_cnt != '0) begin
          p_cnt = p_cnt - 1'b1;
        end else begin
          // decide this channel against both thresholds
          chan_bit = STATUS_W'(1) << p_chan;
          if (p_misses > scan_cfg.min_off_misses && p_hits > scan_cfg.min_on_hits)
            p_detected = p_detected | chan_bit;
          else
            p_detected = p_detected & ~chan_bit;
          p_detected = p_detected & CHAN_MASK;
          decided    = 1'b1;
          p_chan     = (p_chan == CH_W'(CHANNELS - 1)) ? '0 : p_chan + 1'b1;
          p_cnt      = scan_cfg.gap_ticks;
          p_phase    = PH_GAP;
        end
      end
      PH_GAP: begin
        if (p_cnt != '0) p_cnt = p_cnt - 1'b1;
        else p_phase = PH_SELECT;
      end
      default: p_phase = PH_SELECT;
    endcase
    res.mux_select   = MUX_W'(p_chan);
    res.emitter_mask = p_emit ? (MASK_W'(1) << p_chan) : '0;
    res.status_bits  = p_detected;
    res.all_detected = all_set;
    res.channel_done = decided;
    return res;
  endfunction

  // Receiver lines {a, b} for the next tick, from the scene and the predicted emitter
  function automatic logic [1:0] beam_sample(input scene_e sc, input int flip_pct);
    logic [1:0] rx;
    case (sc)
      SC_CLEAR:   rx = {2{p_emit}};
      SC_BLOCKED: rx = 2'b00;
      SC_AMBIENT: rx = 2'b11;
      SC_HALF_A:  rx = {p_emit, 1'b0};
      SC_HALF_B:  rx = {1'b0, p_emit};
      default:    rx = 2'($urandom());
    endcase
    if ($urandom_range(0, 99) < flip_pct) rx[1] = ~rx[1];
    if ($urandom_range(0, 99) < flip_pct) rx[0] = ~rx[0];
    return rx;
  endfunction

  function automatic logic [REG_W-1:0] reg_value(input logic [IDX_W-1:0] idx);
    case (idx)
      REG_ON_WINDOW:      return scan_cfg.on_window;
      REG_OFF_WINDOW:     return scan_cfg.off_window;
      REG_GAP_TICKS:      return scan_cfg.gap_ticks;
      REG_MIN_ON_HITS:    return scan_cfg.min_on_hits;
      REG_MIN_OFF_MISSES: return scan_cfg.min_off_misses;
      default:            return '0;
    endcase
  endfunction

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register with junk in the upper bits; only the low byte counts
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    wdata = ($urandom() & ~DATA_W'(8'hFF)) | DATA_W'(val);
    apb_xfer(1'b1, {idx, 2'b00}, wdata, rdata);
    case (idx)
      REG_ON_WINDOW:      scan_cfg.on_window      = val;
      REG_OFF_WINDOW:     scan_cfg.off_window     = val;
      REG_GAP_TICKS:      scan_cfg.gap_ticks      = val;
      REG_MIN_ON_HITS:    scan_cfg.min_on_hits    = val;
      REG_MIN_OFF_MISSES: scan_cfg.min_off_misses = val;
      default: ;
    endcase
  endtask

  // Read back every register and compare with the shadow copy
  task automatic check_regs();
    logic [DATA_W-1:0] rdata;
    logic [IDX_W-1:0]  idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = IDX_W'(i);
      apb_xfer(1'b0, {idx, 2'b00}, '0, rdata);
      if (rdata !== DATA_W'(reg_value(idx))) begin
        err_cnt++;
        $display("%0t: register %0d readback: expected %0h, actual %0h",
                 $time, i, reg_value(idx), rdata);
      end
    end
  endtask

  task automatic set_config(input logic [REG_W-1:0] on_w, input logic [REG_W-1:0] off_w,
                            input logic [REG_W-1:0] gap, input logic [REG_W-1:0] min_on,
                            input logic [REG_W-1:0] min_off);
    write_reg(REG_ON_WINDOW, on_w);
    write_reg(REG_OFF_WINDOW, off_w);
    write_reg(REG_GAP_TICKS, gap);
    write_reg(REG_MIN_ON_HITS, min_on);
    write_reg(REG_MIN_OFF_MISSES, min_off);
    check_regs();
  endtask

  // Send one tick request; predict its result when it is accepted
  task automatic send_tick(input logic [1:0] rx);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_a_i     <= rx[1];
    rx_b_i     <= rx[0];
    do @(posedge clk_i); while (in_stall_o);
    tick_result_q.push_back(scan_tick(rx[1], rx[0]));
    n_sent++;
  endtask

  // Let every outstanding result arrive, then wait out the DRAIN_WAIT period
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tick_result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random ticks: new scene per channel visit, occasional line flips
  task automatic run_ticks(input int n, input int clear_pct, input int flip_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (p_phase == PH_SELECT) begin
        if ($urandom_range(0, 99) < clear_pct) chan_scene[p_chan] = SC_CLEAR;
        else chan_scene[p_chan] = scene_e'($urandom_range(SC_BLOCKED, SC_NOISE));
      end
      send_tick(beam_sample(chan_scene[p_chan], flip_pct));
    end
    drain();
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Result checker and random output stall
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tick_result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = tick_result_q.pop_front();
          check_field("mux_select", 8'(want.mux_select), 8'(mux_select_o));
          check_field("emitter_mask", want.emitter_mask, emitter_mask_o);
          check_field("status_bits", want.status_bits, status_bits_o);
          check_field("all_detected", 8'(want.all_detected), 8'(all_detected_o));
          check_field("channel_done", 8'(want.channel_done), 8'(channel_done_o));
          n_checked++;
          if (want.channel_done) n_decided++;
          if (want.all_detected) n_all_set++;
        end
        stall_left = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Registers must come out of reset at their documented values
  task automatic test_register_defaults();
    check_regs();
  endtask

  // Shortest windows, one channel per beam condition; stray writes are dropped
  task automatic test_directed_patterns();
    scene_e plan[4];
    plan = '{SC_CLEAR, SC_AMBIENT, SC_HALF_A, SC_HALF_B};
    set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_reg(REG_UNUSED_LO, 8'hFF);
    write_reg(REG_UNUSED_HI, 8'h55);
    check_regs();
    foreach (plan[k]) begin
      repeat (5) send_tick(beam_sample(plan[k], 0));
    end
    drain();
  endtask

  task automatic test_default_timing();
    set_config(RST_ON_WINDOW, RST_OFF_WINDOW, RST_GAP_TICKS,
               RST_MIN_ON_HITS, RST_MIN_OFF_MISSES);
    run_ticks(300, 85, 3);
  endtask

  task automatic test_zero_windows();
    set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_ticks(200, 85, 2);
  endtask

  // Full windows and top thresholds: only a spotless beam reaches them
  task automatic test_max_windows();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_ticks(540, 100, 0);
  endtask

  task automatic test_random_settings();
    for (int r = 0; r < 3; r++) begin
      set_config(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 8'($urandom_range(0, 8)),
                 8'($urandom_range(0, 8)));
      run_ticks(140, 75, 4);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_directed_patterns();
    test_default_timing();
    test_zero_windows();
    test_max_windows();
    test_random_settings();
    drain();
    $display("Covered %0d tick requests and %0d checked results,", n_sent, n_checked);
    $display("with %0d channel decisions and %0d ticks showing all channels detected.",
             n_decided, n_all_set);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0t: %0d mismatches", $time, err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== ir_beam_scan_sequencer_unit.f =====
+incdir+sv
sv/ibss_pkg.sv
sv/ibss_cfg_regs.sv
sv/ibss_scan_core.sv
sv/ir_beam_scan_sequencer_unit.sv
sv/ibss_checker.sv
tb/ir_beam_scan_sequencer_unit_tb.sv
